// File: sv/priority_budget_tier_scheduler_core_assert.svh
// Assertion macros used by the scheduler core.
`ifndef PRIORITY_BUDGET_TIER_SCHEDULER_CORE_ASSERT_SVH
`define PRIORITY_BUDGET_TIER_SCHEDULER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PBTS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("pbts: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PBTS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("pbts: next-cycle check failed");

`endif

// File: sv/pbts_pkg.sv
`timescale 1ns / 1ps
package pbts_pkg;

    localparam int APB_ADDR_W = 5;

    localparam logic [1:0] REQ_SUBMIT   = 2'd0;
    localparam logic [1:0] REQ_REMOVE   = 2'd1;
    localparam logic [1:0] REQ_CLEAR    = 2'd2;
    localparam logic [1:0] REQ_EVALUATE = 2'd3;

    localparam logic [2:0] REG_NEAR_DISTANCE  = 3'd0;
    localparam logic [2:0] REG_MAX_VISIBLE    = 3'd1;
    localparam logic [2:0] REG_MAX_LIVE_SLOTS = 3'd2;
    localparam logic [2:0] REG_MAX_BUILD      = 3'd3;
    localparam logic [2:0] REG_MAX_CHANNELS   = 3'd4;

    localparam int FLAG_SERVER    = 0;
    localparam int FLAG_VIEW      = 1;
    localparam int FLAG_VISIBLE   = 2;
    localparam int FLAG_SUPPORTED = 3;
    localparam int FLAG_ADMIT     = 4;
    localparam int FLAG_BUILD     = 5;
    localparam int FLAG_LIVE      = 6;
    localparam int FLAG_READY     = 7;
    localparam int FLAG_PREVIOUS  = 8;
    localparam int FLAG_CHANGING  = 9;

    localparam logic [1:0] TIER_DESCRIPTOR = 2'd0;
    localparam logic [1:0] TIER_FAR        = 2'd1;
    localparam logic [1:0] TIER_NEAR       = 2'd2;
    localparam logic [1:0] TIER_LIVE       = 2'd3;

    localparam logic [2:0] PEND_NONE        = 3'd0;
    localparam logic [2:0] PEND_OFFSCREEN   = 3'd1;
    localparam logic [2:0] PEND_NO_VIEW     = 3'd2;
    localparam logic [2:0] PEND_SERVER      = 3'd3;
    localparam logic [2:0] PEND_LIVE_WAIT   = 3'd4;
    localparam logic [2:0] PEND_BUILD_WAIT  = 3'd5;
    localparam logic [2:0] PEND_CACHE       = 3'd6;
    localparam logic [2:0] PEND_UNSUPPORTED = 3'd7;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        registration_id;
        logic [31:0]        request_sequence;
        logic signed [7:0]  priority_req;
        logic [23:0]        distance;
        logic [3:0]         channel_count;
        logic [7:0]         live_primitive_count;
        logic [9:0]         flags;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_id;
        logic [31:0] out_sequence;
        logic [1:0]  tier;
        logic [2:0]  pending_reason;
        logic        build_granted;
        logic        live_granted;
        logic        retain_previous;
        logic        release_visuals;
        logic [7:0]  visible_primitives;
        logic        submit_ok;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic signed [7:0]  priority_req;
        logic [23:0]        distance;
        logic [3:0]         channel_count;
        logic [7:0]         live_primitive_count;
        logic [9:0]         flags;
    } attr_t;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] seq;
        attr_t       attr;
    } ent_t;

    typedef struct packed {
        logic [1:0] tier;
        logic [2:0] pend;
        logic       bg;
        logic       lg;
        logic       rp;
        logic       rv;
        logic [7:0] vp;
    } dec_t;

    typedef struct packed {
        logic [23:0] near_distance;
        logic [23:0] max_visible_distance;
        logic [6:0]  max_live_slots;
        logic [6:0]  max_build_units;
        logic [1:0]  max_channels;
    } cfg_t;

endpackage

// File: sv/pbts_cmp.sv
`timescale 1ns / 1ps
module pbts_cmp (
    input  pbts_pkg::attr_t x_attr,
    input  logic [31:0]     x_id,
    input  pbts_pkg::attr_t y_attr,
    input  logic [31:0]     y_id,
    input  logic [23:0]     near_distance,
    output logic            x_ahead
);
    logic x_near, y_near, x_chg, y_chg;

    assign x_near = x_attr.distance <= near_distance;
    assign y_near = y_attr.distance <= near_distance;
    assign x_chg  = x_attr.flags[pbts_pkg::FLAG_CHANGING];
    assign y_chg  = y_attr.flags[pbts_pkg::FLAG_CHANGING];

    always_comb begin
        if ($signed(x_attr.priority_req) != $signed(y_attr.priority_req)) begin
            x_ahead = $signed(x_attr.priority_req) > $signed(y_attr.priority_req);
        end else if (x_near != y_near) begin
            x_ahead = x_near;
        end else if (x_chg != y_chg) begin
            x_ahead = x_chg;
        end else if (x_attr.distance != y_attr.distance) begin
            x_ahead = x_attr.distance < y_attr.distance;
        end else begin
            x_ahead = x_id < y_id;
        end
    end
endmodule

// File: sv/pbts_decide.sv
`timescale 1ns / 1ps
module pbts_decide (
    input  pbts_pkg::attr_t attr,
    input  pbts_pkg::cfg_t  cfg,
    input  logic            build_avail,
    input  logic            live_avail,
    output pbts_pkg::dec_t  dec,
    output logic            take_build,
    output logic            take_live
);
    logic [23:0] vis_max;
    logic [1:0]  ch_cap;
    logic [3:0]  ch_use;
    logic [7:0]  comp;
    logic        nr, need_live;
    logic [9:0]  f;

    assign f         = attr.flags;
    assign vis_max   = (cfg.max_visible_distance > cfg.near_distance) ?
                       cfg.max_visible_distance : cfg.near_distance;
    assign ch_cap    = (cfg.max_channels > 2'd2) ? 2'd2 : cfg.max_channels;
    assign nr        = attr.distance <= cfg.near_distance;
    assign ch_use    = (attr.channel_count < {2'b00, ch_cap}) ?
                       attr.channel_count : {2'b00, ch_cap};
    assign comp      = 8'd1 + (nr ? {4'd0, ch_use} : 8'd0);
    assign need_live = f[pbts_pkg::FLAG_LIVE] && !f[pbts_pkg::FLAG_READY];

    always_comb begin
        dec        = '0;
        dec.rv     = 1'b1;
        take_build = 1'b0;
        take_live  = 1'b0;
        if (f[pbts_pkg::FLAG_SERVER]) begin
            dec.pend = pbts_pkg::PEND_SERVER;
        end else if (!f[pbts_pkg::FLAG_VIEW]) begin
            dec.pend = pbts_pkg::PEND_NO_VIEW;
        end else if (!f[pbts_pkg::FLAG_VISIBLE] || attr.distance > vis_max) begin
            dec.pend = pbts_pkg::PEND_OFFSCREEN;
        end else begin
            dec.rv = 1'b0;
            if (!f[pbts_pkg::FLAG_SUPPORTED]) begin
                dec.pend = pbts_pkg::PEND_UNSUPPORTED;
            end else if (!f[pbts_pkg::FLAG_ADMIT]) begin
                dec.pend = pbts_pkg::PEND_CACHE;
            end else if (f[pbts_pkg::FLAG_BUILD]) begin
                if (build_avail) begin
                    dec.bg     = 1'b1;
                    take_build = 1'b1;
                end else begin
                    dec.pend = pbts_pkg::PEND_BUILD_WAIT;
                end
            end
            if (need_live && live_avail) begin
                dec.tier  = pbts_pkg::TIER_LIVE;
                dec.vp    = (attr.live_primitive_count != 8'd0) ?
                            attr.live_primitive_count : 8'd1;
                dec.lg    = 1'b1;
                take_live = 1'b1;
            end else if (need_live && f[pbts_pkg::FLAG_PREVIOUS]) begin
                dec.tier = nr ? pbts_pkg::TIER_NEAR : pbts_pkg::TIER_FAR;
                dec.vp   = comp;
                dec.rp   = 1'b1;
                dec.pend = pbts_pkg::PEND_LIVE_WAIT;
            end else if (need_live) begin
                dec.rv   = 1'b1;
                dec.pend = pbts_pkg::PEND_LIVE_WAIT;
            end else if (f[pbts_pkg::FLAG_READY] || f[pbts_pkg::FLAG_PREVIOUS]) begin
                dec.tier = nr ? pbts_pkg::TIER_NEAR : pbts_pkg::TIER_FAR;
                dec.vp   = comp;
            end else begin
                dec.rv = 1'b1;
            end
        end
    end
endmodule

// File: sv/priority_budget_tier_scheduler_core.sv
`timescale 1ns / 1ps
// Request table with budgeted tier scheduling.
// Input requests arrive on s_valid/s_ready with an in_item_t payload; results
// leave on m_valid/m_ready with an out_item_t payload. Registers are written
// over the APB port (pready is always high); the user must make all writes while
// idle, as the block does not enforce it. A submit with a nonzero id scans
// every table slot, one a cycle, then returns one result; a submit with id zero
// returns a refusal without a scan. A remove scans the same way and a clear
// empties the table; neither returns a result. An evaluate ranks each valid
// entry against all slots through the shared comparator. Budgets are then
// spent in rank order, and decisions leave in ascending id order, last
// marking the final one.
// Throughput is bound by the single read port of the entry memory.
// Reset empties the table and restores register defaults. A stalled
// receiver holds the output register; the sequencer waits for it to drain.
// The next request is taken while an earlier result still waits.
module priority_budget_tier_scheduler_core #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  pbts_pkg::in_item_t            s_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output pbts_pkg::out_item_t           m_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pbts_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    `include "priority_budget_tier_scheduler_core_assert.svh"

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] N_CNT = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_SUB_OUT, ST_RA_ISSUE, ST_RA_LATCH, ST_RB,
        ST_BG_IDX, ST_BG_RD, ST_BG_DEC, ST_OP_IDX, ST_OP_RD, ST_OP_LOAD
    } state_t;

    state_t                   state_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    pbts_pkg::cfg_t           cfg_reg;
    pbts_pkg::in_item_t       req_reg;
    logic [CNT_W-1:0]         cnt_reg, a_reg, n_reg, r_reg;
    logic                     p_vld_reg;
    logic [IDX_W-1:0]         p_idx_reg, hit_slot_reg, free_slot_reg, slot_reg;
    logic [IDX_W-1:0]         rank_reg, idrank_reg;
    logic                     found_reg, free_found_reg, sub_ok_reg;
    logic [31:0]              hit_seq_reg;
    pbts_pkg::ent_t           a_rec_reg;
    logic [6:0]               build_left_reg, live_left_reg;
    logic                     m_valid_reg;
    pbts_pkg::out_item_t      m_item_reg;

    pbts_pkg::ent_t ent_mem [TABLE_ENTRIES];
    logic [IDX_W-1:0] ord_mem [TABLE_ENTRIES];
    logic [IDX_W-1:0] idx_mem [TABLE_ENTRIES];
    pbts_pkg::dec_t dec_mem [TABLE_ENTRIES];

    pbts_pkg::ent_t   ent_rdata, ent_wdata;
    logic [IDX_W-1:0] ord_rdata, idx_rdata;
    pbts_pkg::dec_t   dec_rdata, dec_out;
    logic             ent_re, ord_re, idx_re, dec_re;
    logic             ent_we, rank_we, dec_we;
    logic [IDX_W-1:0] ent_raddr, ord_raddr, idx_raddr, dec_raddr, ent_waddr;

    logic scan_done, p_hit, p_free, sub_ok, out_free, b_ahead, m_load;
    logic take_build, take_live, cfg_wr;
    logic [IDX_W-1:0] sub_slot;

    assign scan_done = (cnt_reg == N_CNT) && !p_vld_reg;
    assign p_hit     = p_vld_reg && valid_reg[p_idx_reg] &&
                       (ent_rdata.id == req_reg.registration_id);
    assign p_free    = p_vld_reg && !valid_reg[p_idx_reg];
    assign sub_ok    = found_reg ? (req_reg.request_sequence >= hit_seq_reg) : free_found_reg;
    assign sub_slot  = found_reg ? hit_slot_reg : free_slot_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_load    = out_free && (state_reg == ST_SUB_OUT || state_reg == ST_OP_LOAD);
    assign cfg_wr    = psel && penable && pwrite && pready;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;
    assign pready  = 1'b1;

    pbts_cmp u_cmp (
        .x_attr        (ent_rdata.attr),
        .x_id          (ent_rdata.id),
        .y_attr        (a_rec_reg.attr),
        .y_id          (a_rec_reg.id),
        .near_distance (cfg_reg.near_distance),
        .x_ahead       (b_ahead)
    );

    pbts_decide u_decide (
        .attr        (ent_rdata.attr),
        .cfg         (cfg_reg),
        .build_avail (build_left_reg != 7'd0),
        .live_avail  (live_left_reg != 7'd0),
        .dec         (dec_out),
        .take_build  (take_build),
        .take_live   (take_live)
    );

    always_comb begin
        case (paddr[4:2])
            pbts_pkg::REG_NEAR_DISTANCE:  prdata = {8'd0, cfg_reg.near_distance};
            pbts_pkg::REG_MAX_VISIBLE:    prdata = {8'd0, cfg_reg.max_visible_distance};
            pbts_pkg::REG_MAX_LIVE_SLOTS: prdata = {25'd0, cfg_reg.max_live_slots};
            pbts_pkg::REG_MAX_BUILD:      prdata = {25'd0, cfg_reg.max_build_units};
            pbts_pkg::REG_MAX_CHANNELS:   prdata = {30'd0, cfg_reg.max_channels};
            default:                      prdata = 32'd0;
        endcase
    end

    always_comb begin
        ent_re    = 1'b0;
        ord_re    = 1'b0;
        idx_re    = 1'b0;
        dec_re    = 1'b0;
        ent_raddr = '0;
        ord_raddr = r_reg[IDX_W-1:0];
        idx_raddr = r_reg[IDX_W-1:0];
        dec_raddr = idx_rdata;
        case (state_reg)
            ST_SCAN, ST_RB: begin
                if (cnt_reg != N_CNT) begin
                    ent_re    = 1'b1;
                    ent_raddr = cnt_reg[IDX_W-1:0];
                end
            end
            ST_RA_ISSUE: begin
                if (a_reg != N_CNT && valid_reg[a_reg[IDX_W-1:0]]) begin
                    ent_re    = 1'b1;
                    ent_raddr = a_reg[IDX_W-1:0];
                end
            end
            ST_BG_IDX: ord_re = 1'b1;
            ST_BG_RD: begin
                ent_re    = 1'b1;
                ent_raddr = ord_rdata;
            end
            ST_OP_IDX: idx_re = 1'b1;
            ST_OP_RD: begin
                ent_re    = 1'b1;
                dec_re    = 1'b1;
                ent_raddr = idx_rdata;
            end
            default: ;
        endcase
    end

    assign ent_we = (state_reg == ST_SCAN) && scan_done &&
                    (req_reg.req_type == pbts_pkg::REQ_SUBMIT) && sub_ok;
    assign ent_waddr      = sub_slot;
    assign ent_wdata.id   = req_reg.registration_id;
    assign ent_wdata.seq  = req_reg.request_sequence;
    assign ent_wdata.attr = {req_reg.priority_req, req_reg.distance, req_reg.channel_count,
                             req_reg.live_primitive_count, req_reg.flags};
    assign rank_we = (state_reg == ST_RB) && scan_done;
    assign dec_we  = (state_reg == ST_BG_DEC);

    always_ff @(posedge aclk) begin
        if (ent_we) begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re) begin
            ent_rdata <= ent_mem[ent_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (rank_we) begin
            ord_mem[rank_reg]   <= a_reg[IDX_W-1:0];
            idx_mem[idrank_reg] <= a_reg[IDX_W-1:0];
        end
        if (ord_re) begin
            ord_rdata <= ord_mem[ord_raddr];
        end
        if (idx_re) begin
            idx_rdata <= idx_mem[idx_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (dec_we) begin
            dec_mem[slot_reg] <= dec_out;
        end
        if (dec_re) begin
            dec_rdata <= dec_mem[dec_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg                    <= ST_IDLE;
            valid_reg                    <= '0;
            p_vld_reg                    <= 1'b0;
            m_valid_reg                  <= 1'b0;
            cfg_reg.near_distance        <= 24'd0;
            cfg_reg.max_visible_distance <= 24'hFFFFFF;
            cfg_reg.max_live_slots       <= 7'd4;
            cfg_reg.max_build_units      <= 7'd1;
            cfg_reg.max_channels         <= 2'd2;
        end else begin
            if (cfg_wr) begin
                case (paddr[4:2])
                    pbts_pkg::REG_NEAR_DISTANCE:  cfg_reg.near_distance <= pwdata[23:0];
                    pbts_pkg::REG_MAX_VISIBLE:    cfg_reg.max_visible_distance <= pwdata[23:0];
                    pbts_pkg::REG_MAX_LIVE_SLOTS: cfg_reg.max_live_slots <= pwdata[6:0];
                    pbts_pkg::REG_MAX_BUILD:      cfg_reg.max_build_units <= pwdata[6:0];
                    pbts_pkg::REG_MAX_CHANNELS:   cfg_reg.max_channels <= pwdata[1:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready && !m_load) begin
                m_valid_reg <= 1'b0;
            end
            // Shared slot walk: the read issued last cycle is checked now.
            if (state_reg == ST_SCAN || state_reg == ST_RB) begin
                if (cnt_reg != N_CNT) begin
                    p_vld_reg <= 1'b1;
                    p_idx_reg <= cnt_reg[IDX_W-1:0];
                    cnt_reg   <= cnt_reg + ONE_CNT;
                end else begin
                    p_vld_reg <= 1'b0;
                end
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg        <= s_item;
                        cnt_reg        <= '0;
                        p_vld_reg      <= 1'b0;
                        found_reg      <= 1'b0;
                        free_found_reg <= 1'b0;
                        case (s_item.req_type)
                            pbts_pkg::REQ_SUBMIT: begin
                                if (s_item.registration_id == 32'd0) begin
                                    sub_ok_reg <= 1'b0;
                                    state_reg  <= ST_SUB_OUT;
                                end else begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            pbts_pkg::REQ_REMOVE: state_reg <= ST_SCAN;
                            pbts_pkg::REQ_CLEAR:  valid_reg <= '0;
                            default: begin
                                a_reg          <= '0;
                                n_reg          <= '0;
                                build_left_reg <= cfg_reg.max_build_units;
                                live_left_reg  <= cfg_reg.max_live_slots;
                                state_reg      <= ST_RA_ISSUE;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (p_hit && !found_reg) begin
                        found_reg    <= 1'b1;
                        hit_slot_reg <= p_idx_reg;
                        hit_seq_reg  <= ent_rdata.seq;
                    end
                    if (p_free && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                        free_slot_reg  <= p_idx_reg;
                    end
                    if (scan_done) begin
                        if (req_reg.req_type == pbts_pkg::REQ_SUBMIT) begin
                            sub_ok_reg <= sub_ok;
                            if (sub_ok) begin
                                valid_reg[sub_slot] <= 1'b1;
                            end
                            state_reg <= ST_SUB_OUT;
                        end else begin
                            if (found_reg) begin
                                valid_reg[hit_slot_reg] <= 1'b0;
                            end
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_SUB_OUT: begin
                    if (out_free) begin
                        m_valid_reg                   <= 1'b1;
                        m_item_reg.out_id             <= req_reg.registration_id;
                        m_item_reg.out_sequence       <= req_reg.request_sequence;
                        m_item_reg.tier               <= pbts_pkg::TIER_DESCRIPTOR;
                        m_item_reg.pending_reason     <= pbts_pkg::PEND_NONE;
                        m_item_reg.build_granted      <= 1'b0;
                        m_item_reg.live_granted       <= 1'b0;
                        m_item_reg.retain_previous    <= 1'b0;
                        m_item_reg.release_visuals    <= 1'b0;
                        m_item_reg.visible_primitives <= 8'd0;
                        m_item_reg.submit_ok          <= sub_ok_reg;
                        m_item_reg.last               <= 1'b0;
                        state_reg                     <= ST_IDLE;
                    end
                end
                ST_RA_ISSUE: begin
                    if (a_reg == N_CNT) begin
                        r_reg     <= '0;
                        state_reg <= (n_reg == '0) ? ST_IDLE : ST_BG_IDX;
                    end else if (valid_reg[a_reg[IDX_W-1:0]]) begin
                        state_reg <= ST_RA_LATCH;
                    end else begin
                        a_reg <= a_reg + ONE_CNT;
                    end
                end
                ST_RA_LATCH: begin
                    a_rec_reg  <= ent_rdata;
                    cnt_reg    <= '0;
                    p_vld_reg  <= 1'b0;
                    rank_reg   <= '0;
                    idrank_reg <= '0;
                    state_reg  <= ST_RB;
                end
                ST_RB: begin
                    // Count the entries ranking ahead and those with a smaller id.
                    if (p_vld_reg && valid_reg[p_idx_reg] &&
                        p_idx_reg != a_reg[IDX_W-1:0]) begin
                        if (b_ahead) begin
                            rank_reg <= rank_reg + IDX_W'(1);
                        end
                        if (ent_rdata.id < a_rec_reg.id) begin
                            idrank_reg <= idrank_reg + IDX_W'(1);
                        end
                    end
                    if (scan_done) begin
                        n_reg     <= n_reg + ONE_CNT;
                        a_reg     <= a_reg + ONE_CNT;
                        state_reg <= ST_RA_ISSUE;
                    end
                end
                ST_BG_IDX: state_reg <= ST_BG_RD;
                ST_BG_RD: begin
                    slot_reg  <= ord_rdata;
                    state_reg <= ST_BG_DEC;
                end
                ST_BG_DEC: begin
                    if (take_build) begin
                        build_left_reg <= build_left_reg - 7'd1;
                    end
                    if (take_live) begin
                        live_left_reg <= live_left_reg - 7'd1;
                    end
                    if (r_reg + ONE_CNT == n_reg) begin
                        r_reg     <= '0;
                        state_reg <= ST_OP_IDX;
                    end else begin
                        r_reg     <= r_reg + ONE_CNT;
                        state_reg <= ST_BG_IDX;
                    end
                end
                ST_OP_IDX: state_reg <= ST_OP_RD;
                ST_OP_RD:  state_reg <= ST_OP_LOAD;
                ST_OP_LOAD: begin
                    if (out_free) begin
                        m_valid_reg                   <= 1'b1;
                        m_item_reg.out_id             <= ent_rdata.id;
                        m_item_reg.out_sequence       <= ent_rdata.seq;
                        m_item_reg.tier               <= dec_rdata.tier;
                        m_item_reg.pending_reason     <= dec_rdata.pend;
                        m_item_reg.build_granted      <= dec_rdata.bg;
                        m_item_reg.live_granted       <= dec_rdata.lg;
                        m_item_reg.retain_previous    <= dec_rdata.rp;
                        m_item_reg.release_visuals    <= dec_rdata.rv;
                        m_item_reg.visible_primitives <= dec_rdata.vp;
                        m_item_reg.submit_ok          <= 1'b0;
                        m_item_reg.last               <= (r_reg + ONE_CNT == n_reg);
                        if (r_reg + ONE_CNT == n_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            r_reg     <= r_reg + ONE_CNT;
                            state_reg <= ST_OP_IDX;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `PBTS_ASSERT_NXT(a_busy_after_req, aclk, aresetn,
        s_valid && s_ready && s_item.req_type != pbts_pkg::REQ_CLEAR, !s_ready)
    `PBTS_ASSERT_IMP(a_ok_not_last, aclk, aresetn,
        m_valid && m_item.submit_ok, !m_item.last)
    `PBTS_ASSERT_IMP(a_build_budget, aclk, aresetn,
        state_reg == ST_BG_DEC && take_build, build_left_reg != 7'd0)
    `PBTS_ASSERT_IMP(a_sub_out_is_submit, aclk, aresetn,
        state_reg == ST_SUB_OUT, req_reg.req_type == pbts_pkg::REQ_SUBMIT)

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

    localparam int ENTRIES = 64;
    localparam int IDLE_LIMIT = 400000;
    localparam int DRAIN_GAP = 300;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    pbts_pkg::in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    pbts_pkg::out_item_t m_item;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [pbts_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    priority_budget_tier_scheduler_core #(.TABLE_ENTRIES(ENTRIES)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Shadow of the request table and registers.
    logic              tbl_valid [ENTRIES];
    logic [31:0]       tbl_id    [ENTRIES];
    logic [31:0]       tbl_seq   [ENTRIES];
    pbts_pkg::attr_t   tbl_attr  [ENTRIES];
    pbts_pkg::cfg_t    cfg;

    pbts_pkg::out_item_t pending_decisions[$];
    int        errors = 0;
    int        idle_cycles = 0;
    int        accepted_reqs = 0;
    bit        quiet = 1'b0;
    bit        recv_quiet = 1'b0;
    logic [31:0] id_pool[8];

    task automatic report_mismatch(input string what, input pbts_pkg::out_item_t got,
                                   input pbts_pkg::out_item_t want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic is_near(input int s);
        return tbl_attr[s].distance <= cfg.near_distance;
    endfunction

    function automatic logic ahead_of(input int a, input int b);
        logic na, nb, ca, cb;
        if (tbl_attr[a].priority_req != tbl_attr[b].priority_req)
            return tbl_attr[a].priority_req > tbl_attr[b].priority_req;
        na = is_near(a);
        nb = is_near(b);
        if (na != nb) return na;
        ca = tbl_attr[a].flags[pbts_pkg::FLAG_CHANGING];
        cb = tbl_attr[b].flags[pbts_pkg::FLAG_CHANGING];
        if (ca != cb) return ca;
        if (tbl_attr[a].distance != tbl_attr[b].distance)
            return tbl_attr[a].distance < tbl_attr[b].distance;
        return tbl_id[a] < tbl_id[b];
    endfunction

    // Applies one request to the shadow table and queues the decisions it yields.
    task automatic schedule_request(input pbts_pkg::in_item_t r);
        int order[$];
        pbts_pkg::dec_t dec[ENTRIES];
        int s, k, j, n;
        logic ok, nr, need_live;
        logic [6:0] live_left, build_left;
        logic [23:0] vis_max;
        logic [1:0] ch_cap;
        logic [7:0] comp;
        logic [9:0] f;
        pbts_pkg::out_item_t o;
        s = -1;
        ok = 1'b0;
        case (r.req_type)
            pbts_pkg::REQ_SUBMIT: begin
                if (r.registration_id != 0) begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (s < 0 && tbl_valid[i] && tbl_id[i] == r.registration_id) s = i;
                    if (s >= 0) begin
                        ok = r.request_sequence >= tbl_seq[s];
                    end else begin
                        for (int i = 0; i < ENTRIES; i++)
                            if (s < 0 && !tbl_valid[i]) s = i;
                        ok = s >= 0;
                    end
                    if (ok) begin
                        tbl_valid[s] = 1'b1;
                        tbl_id[s] = r.registration_id;
                        tbl_seq[s] = r.request_sequence;
                        tbl_attr[s] = {r.priority_req, r.distance, r.channel_count,
                                       r.live_primitive_count, r.flags};
                    end
                end
                o = '0;
                o.out_id = r.registration_id;
                o.out_sequence = r.request_sequence;
                o.submit_ok = ok;
                pending_decisions.push_back(o);
            end
            pbts_pkg::REQ_REMOVE: begin
                for (int i = 0; i < ENTRIES; i++)
                    if (tbl_valid[i] && tbl_id[i] == r.registration_id) tbl_valid[i] = 1'b0;
            end
            pbts_pkg::REQ_CLEAR: begin
                for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
            end
            default: begin
                live_left = cfg.max_live_slots;
                build_left = cfg.max_build_units;
                vis_max = cfg.max_visible_distance > cfg.near_distance ?
                          cfg.max_visible_distance : cfg.near_distance;
                ch_cap = cfg.max_channels > 2 ? 2'd2 : cfg.max_channels;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (tbl_valid[i]) begin
                        j = 0;
                        while (j < order.size() && !ahead_of(i, order[j])) j++;
                        order.insert(j, i);
                    end
                end
                n = order.size();
                for (int i = 0; i < n; i++) begin
                    s = order[i];
                    f = tbl_attr[s].flags;
                    dec[s] = '0;
                    dec[s].rv = 1'b1;
                    if (f[pbts_pkg::FLAG_SERVER]) dec[s].pend = pbts_pkg::PEND_SERVER;
                    else if (!f[pbts_pkg::FLAG_VIEW]) dec[s].pend = pbts_pkg::PEND_NO_VIEW;
                    else if (!f[pbts_pkg::FLAG_VISIBLE] || tbl_attr[s].distance > vis_max)
                        dec[s].pend = pbts_pkg::PEND_OFFSCREEN;
                    else begin
                        dec[s].rv = 1'b0;
                        nr = is_near(s);
                        comp = 8'd1;
                        if (nr) comp += (tbl_attr[s].channel_count < ch_cap) ?
                                        tbl_attr[s].channel_count : ch_cap;
                        if (!f[pbts_pkg::FLAG_SUPPORTED])
                            dec[s].pend = pbts_pkg::PEND_UNSUPPORTED;
                        else if (!f[pbts_pkg::FLAG_ADMIT]) dec[s].pend = pbts_pkg::PEND_CACHE;
                        else if (f[pbts_pkg::FLAG_BUILD]) begin
                            if (build_left > 0) begin
                                dec[s].bg = 1'b1;
                                build_left--;
                            end else begin
                                dec[s].pend = pbts_pkg::PEND_BUILD_WAIT;
                            end
                        end
                        need_live = f[pbts_pkg::FLAG_LIVE] && !f[pbts_pkg::FLAG_READY];
                        if (need_live && live_left > 0) begin
                            dec[s].tier = pbts_pkg::TIER_LIVE;
                            dec[s].vp = tbl_attr[s].live_primitive_count > 0 ?
                                        tbl_attr[s].live_primitive_count : 8'd1;
                            dec[s].lg = 1'b1;
                            live_left--;
                        end else if (need_live && f[pbts_pkg::FLAG_PREVIOUS]) begin
                            dec[s].tier = nr ? pbts_pkg::TIER_NEAR : pbts_pkg::TIER_FAR;
                            dec[s].vp = comp;
                            dec[s].rp = 1'b1;
                            dec[s].pend = pbts_pkg::PEND_LIVE_WAIT;
                        end else if (need_live) begin
                            dec[s].rv = 1'b1;
                            dec[s].pend = pbts_pkg::PEND_LIVE_WAIT;
                        end else if (f[pbts_pkg::FLAG_READY] || f[pbts_pkg::FLAG_PREVIOUS]) begin
                            dec[s].tier = nr ? pbts_pkg::TIER_NEAR : pbts_pkg::TIER_FAR;
                            dec[s].vp = comp;
                        end else begin
                            dec[s].rv = 1'b1;
                        end
                    end
                end
                // Decisions leave in ascending id order.
                for (int i = 1; i < n; i++) begin
                    k = order[i];
                    for (j = i; j > 0 && tbl_id[k] < tbl_id[order[j-1]]; j--)
                        order[j] = order[j-1];
                    order[j] = k;
                end
                for (int i = 0; i < n; i++) begin
                    s = order[i];
                    o = '0;
                    o.out_id = tbl_id[s];
                    o.out_sequence = tbl_seq[s];
                    {o.tier, o.pending_reason, o.build_granted, o.live_granted,
                     o.retain_previous, o.release_visuals, o.visible_primitives} = dec[s];
                    o.last = (i == n - 1);
                    pending_decisions.push_back(o);
                end
            end
        endcase
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= pbts_pkg::APB_ADDR_W'(idx) << 2;
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            pbts_pkg::REG_NEAR_DISTANCE:  cfg.near_distance = val[23:0];
            pbts_pkg::REG_MAX_VISIBLE:    cfg.max_visible_distance = val[23:0];
            pbts_pkg::REG_MAX_LIVE_SLOTS: cfg.max_live_slots = val[6:0];
            pbts_pkg::REG_MAX_BUILD:      cfg.max_build_units = val[6:0];
            default:                      cfg.max_channels = val[1:0];
        endcase
    endtask

    task automatic wait_drained();
        while (pending_decisions.size() != 0) @(posedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [23:0] nd, input logic [23:0] mv,
                              input logic [6:0] ls, input logic [6:0] bu,
                              input logic [1:0] mc);
        wait_drained();
        write_reg(pbts_pkg::REG_NEAR_DISTANCE, 32'(nd));
        write_reg(pbts_pkg::REG_MAX_VISIBLE, 32'(mv));
        write_reg(pbts_pkg::REG_MAX_LIVE_SLOTS, 32'(ls));
        write_reg(pbts_pkg::REG_MAX_BUILD, 32'(bu));
        write_reg(pbts_pkg::REG_MAX_CHANNELS, 32'(mc));
    endtask

    task automatic send_request(input pbts_pkg::in_item_t r);
        if (!quiet) begin
            while ($urandom_range(99) < 37) @(negedge aclk);
        end
        s_item <= r;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        schedule_request(r);
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    function automatic pbts_pkg::in_item_t mk(input logic [1:0] t, input logic [31:0] id,
                                              input logic [31:0] sq, input logic [7:0] pr,
                                              input logic [23:0] d, input logic [3:0] ch,
                                              input logic [7:0] lp, input logic [9:0] fl);
        pbts_pkg::in_item_t r;
        r.req_type = t;
        r.registration_id = id;
        r.request_sequence = sq;
        r.priority_req = pr;
        r.distance = d;
        r.channel_count = ch;
        r.live_primitive_count = lp;
        r.flags = fl;
        return r;
    endfunction

    function automatic pbts_pkg::in_item_t random_request(input int kind);
        pbts_pkg::in_item_t r;
        r = mk(pbts_pkg::REQ_SUBMIT, id_pool[$urandom_range(7)], $urandom_range(40),
               $urandom, $urandom, $urandom, $urandom, $urandom);
        // Mostly well formed: visible, supported, admitted entries.
        if ($urandom_range(3) != 0) r.flags[4:1] = 4'b1111;
        if ($urandom_range(3) != 0) r.flags[pbts_pkg::FLAG_SERVER] = 1'b0;
        if ($urandom_range(1)) r.distance = $urandom_range(3000);
        if ($urandom_range(9) == 0) r.registration_id = $urandom;
        if ($urandom_range(19) == 0) r.request_sequence = $urandom;
        if ($urandom_range(1)) r.priority_req = $urandom_range(3);
        if (kind < 8) r.req_type = pbts_pkg::REQ_EVALUATE;
        else if (kind < 14) r.req_type = pbts_pkg::REQ_REMOVE;
        else if (kind == 14) r.req_type = pbts_pkg::REQ_CLEAR;
        return r;
    endfunction

    // Result checking and receiver stalls.
    always @(posedge aclk) begin
        pbts_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            idle_cycles = 0;
            if (pending_decisions.size() == 0) begin
                report_mismatch("unexpected", m_item, '0);
            end else begin
                want = pending_decisions.pop_front();
                if (m_item.out_id != want.out_id) report_mismatch("out_id", m_item, want);
                if (m_item.out_sequence != want.out_sequence)
                    report_mismatch("out_sequence", m_item, want);
                if (m_item.tier != want.tier) report_mismatch("tier", m_item, want);
                if (m_item.pending_reason != want.pending_reason)
                    report_mismatch("pending_reason", m_item, want);
                if (m_item.build_granted != want.build_granted)
                    report_mismatch("build_granted", m_item, want);
                if (m_item.live_granted != want.live_granted)
                    report_mismatch("live_granted", m_item, want);
                if (m_item.retain_previous != want.retain_previous)
                    report_mismatch("retain_previous", m_item, want);
                if (m_item.release_visuals != want.release_visuals)
                    report_mismatch("release_visuals", m_item, want);
                if (m_item.visible_primitives != want.visible_primitives)
                    report_mismatch("visible_primitives", m_item, want);
                if (m_item.submit_ok != want.submit_ok)
                    report_mismatch("submit_ok", m_item, want);
                if (m_item.last != want.last) report_mismatch("last", m_item, want);
            end
        end else if (aresetn && s_valid && s_ready) begin
            idle_cycles = 0;
        end else if (aresetn) begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= recv_quiet || ($urandom_range(99) >= 37);
    end

    // Directed rows: request plus, where obvious, the submit verdict.
    typedef struct {
        pbts_pkg::in_item_t req;
        logic               known;
        logic               ok;
    } row_t;

    initial begin
        row_t rows[$];
        pbts_pkg::in_item_t r;
        int kind;
        cfg = '{24'd0, 24'hFFFFFF, 7'd4, 7'd1, 2'd2};
        for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
        for (int i = 0; i < 8; i++) id_pool[i] = (i == 7) ? 32'hFFFF_FFFF : 32'(i * 3 + 1);
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: evaluate of an empty table yields nothing.
        rows.push_back('{mk(pbts_pkg::REQ_EVALUATE, 0, 0, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{mk(pbts_pkg::REQ_SUBMIT, 0, 5, 0, 0, 0, 0, 10'h3FF), 1, 0});
        rows.push_back('{mk(pbts_pkg::REQ_SUBMIT, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'h7F,
                            24'hFFFFFF, 4'hF, 8'hFF, 10'h3FF), 1, 1});
        rows.push_back('{mk(pbts_pkg::REQ_SUBMIT, 1, 10, 8'h80, 0, 0, 0, 10'h0DE), 1, 1});
        rows.push_back('{mk(pbts_pkg::REQ_SUBMIT, 1, 9, 0, 0, 0, 0, 0), 1, 0});
        rows.push_back('{mk(pbts_pkg::REQ_SUBMIT, 1, 10, 8'h80, 0, 4'd5, 8'd0, 10'h05E),
                         1, 1});
        rows.push_back('{mk(pbts_pkg::REQ_SUBMIT, 2, 0, 0, 24'd100, 4'd1, 8'd7, 10'h15E),
                         1, 1});
        rows.push_back('{mk(pbts_pkg::REQ_SUBMIT, 3, 0, 0, 24'd100, 4'd1, 8'd7, 10'h27E),
                         1, 1});
        rows.push_back('{mk(pbts_pkg::REQ_SUBMIT, 4, 0, 0, 0, 0, 0, 10'h001), 1, 1});
        rows.push_back('{mk(pbts_pkg::REQ_SUBMIT, 5, 0, 0, 0, 0, 0, 10'h000), 1, 1});
        rows.push_back('{mk(pbts_pkg::REQ_SUBMIT, 6, 0, 0, 0, 0, 0, 10'h002), 1, 1});
        rows.push_back('{mk(pbts_pkg::REQ_SUBMIT, 7, 0, 0, 0, 0, 0, 10'h006), 1, 1});
        rows.push_back('{mk(pbts_pkg::REQ_SUBMIT, 8, 0, 0, 0, 0, 0, 10'h00E), 1, 1});
        rows.push_back('{mk(pbts_pkg::REQ_SUBMIT, 9, 0, 0, 0, 0, 0, 10'h03E), 1, 1});
        rows.push_back('{mk(pbts_pkg::REQ_SUBMIT, 10, 0, 0, 0, 0, 0, 10'h09E), 1, 1});
        rows.push_back('{mk(pbts_pkg::REQ_EVALUATE, 0, 0, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{mk(pbts_pkg::REQ_REMOVE, 99, 0, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{mk(pbts_pkg::REQ_REMOVE, 4, 0, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{mk(pbts_pkg::REQ_EVALUATE, 0, 0, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{mk(pbts_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0), 0, 0});
        rows.push_back('{mk(pbts_pkg::REQ_EVALUATE, 0, 0, 0, 0, 0, 0, 0), 0, 0});
        foreach (rows[i]) begin
            send_request(rows[i].req);
            if (rows[i].known && pending_decisions[$].submit_ok != rows[i].ok) begin
                report_mismatch("directed verdict", pending_decisions[$], '0);
            end
        end

        // Fill the table so a new id is refused.
        set_config(24'd500, 24'd2000, 7'd2, 7'd3, 2'd3);
        for (int i = 0; i < ENTRIES; i++)
            send_request(mk(pbts_pkg::REQ_SUBMIT, 32'(1000 + i), 0, 0, 24'(i * 40), 4'd3,
                            8'(i), 10'h0DE));
        send_request(mk(pbts_pkg::REQ_SUBMIT, 32'd5000, 0, 0, 0, 0, 0, 0));
        send_request(mk(pbts_pkg::REQ_EVALUATE, 0, 0, 0, 0, 0, 0, 0));
        send_request(mk(pbts_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0));

        // Random traffic over several settings.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_config(24'd0, 24'hFFFFFF, 7'd4, 7'd1, 2'd2);
                1: set_config(24'hFFFFFF, 24'd0, 7'd0, 7'd0, 2'd0);
                2: set_config(24'd1500, 24'd1000, 7'd64, 7'd64, 2'd1);
                3: set_config($urandom_range(3000), $urandom_range(3000),
                              $urandom_range(64), $urandom_range(64), $urandom_range(3));
                default: set_config(24'd800, 24'd2500, 7'd1, 7'd2, 2'd3);
            endcase
            quiet = (phase == 2);
            recv_quiet = (phase == 2);
            for (int i = 0; i < 66; i++) begin
                kind = $urandom_range(99);
                if (kind >= 30) kind = 20;
                r = random_request(kind);
                send_request(r);
                if (i == 33) wait_drained();
            end
        end
        quiet = 1'b0;
        recv_quiet = 1'b0;
        send_request(mk(pbts_pkg::REQ_EVALUATE, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+sv
sv/pbts_pkg.sv
sv/pbts_cmp.sv
sv/pbts_decide.sv
sv/priority_budget_tier_scheduler_core.sv
tb/testbench.sv
